// ===== design/dcr_pkg.sv =====
// Shared widths, the sideband item record and the saturation function
// for the disk collision response pipeline. No dependencies.
package dcr_pkg;

    localparam int DATA_W    = 16;
    localparam int RAD_W     = 15;
    localparam int MASS_W    = 16;
    localparam int REST_W    = 16;
    localparam int REST_FRAC = 15;

    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DD_W   = PROD_W + 1;
    localparam int RS_W   = RAD_W + 1;
    localparam int RS2_W  = 2 * RS_W;
    localparam int K_W    = REST_FRAC + 2;
    localparam int M_W    = MASS_W + 1;
    localparam int Q_W    = DATA_W + 3;
    localparam int PM_W   = Q_W + MASS_W;
    localparam int NUM_W  = PM_W + K_W;
    localparam int DEN_W  = PROD_W;
    localparam int CMP_W  = DEN_W + Q_W;
    localparam int SUM_W  = Q_W + 2;

    localparam logic [REST_W-1:0] REST_RESET = REST_W'(29491);
    localparam logic [K_W-1:0]    REST_ONE   = K_W'(1) << REST_FRAC;

    typedef struct packed {
        logic signed [DATA_W-1:0] vel1x;
        logic signed [DATA_W-1:0] vel1y;
        logic signed [DATA_W-1:0] vel2x;
        logic signed [DATA_W-1:0] vel2y;
        logic [MASS_W-1:0]        m1;
        logic [MASS_W-1:0]        m2;
        logic [K_W-1:0]           k;
        logic                     collide;
        logic                     sx;
        logic                     sy;
    } side_t;

    function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [DATA_W-1:0] r;
        hi = $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}}));
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            r = hi[DATA_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/dcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounding the
// final quotient to nearest with ties up. Depends on dcr_pkg.
module dcr_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [dcr_pkg::NUM_W-1:0]  mag,
    input  logic [dcr_pkg::DEN_W-1:0]  den,
    output logic [dcr_pkg::Q_W-1:0]    quo
);
    import dcr_pkg::*;

    logic [NUM_W-1:0] rem_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [NUM_W:0]   rem2;
    logic [NUM_W:0]   den2;
    logic             up;

    generate
        for (genvar s = 0; s < Q_W; s++)
        begin : g_stage
            localparam int SHIFT = Q_W - 1 - s;
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   quo_in;
            logic [CMP_W-1:0] rem_ext;
            logic [CMP_W-1:0] den_shift;
            logic [CMP_W-1:0] diff;
            logic             take;

            if (s == 0)
            begin : g_first
                assign rem_in = mag;
                assign den_in = den;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[s-1];
                assign den_in = den_reg[s-1];
                assign quo_in = quo_reg[s-1];
            end

            assign rem_ext   = CMP_W'(rem_in);
            assign den_shift = CMP_W'(den_in) << SHIFT;
            assign diff      = rem_ext - den_shift;
            assign take      = rem_ext >= den_shift;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? diff[NUM_W-1:0] : rem_in;
                    den_reg[s] <= den_in;
                    quo_reg[s] <= take ? (quo_in | (Q_W'(1) << SHIFT)) : quo_in;
                end
            end
        end
    endgenerate

    assign rem2 = {rem_reg[Q_W-1], 1'b0};
    assign den2 = (NUM_W+1)'(den_reg[Q_W-1]);
    assign up   = rem2 >= den2;
    assign quo  = quo_reg[Q_W-1] + Q_W'(up);

endmodule

// ===== design/dcr_front.sv =====
// Geometry front end: center and velocity differences, squared distance,
// approach test and the numerators of the projection, over four stages.
// Depends on dcr_pkg.
module dcr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_pos_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_pos_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_pos_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_pos_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_vel_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_vel_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_vel_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_vel_y,
    input  logic [dcr_pkg::RAD_W-1:0]         first_radius,
    input  logic [dcr_pkg::RAD_W-1:0]         second_radius,
    input  logic [dcr_pkg::MASS_W-1:0]        first_mass,
    input  logic [dcr_pkg::MASS_W-1:0]        second_mass,
    input  logic [dcr_pkg::REST_W-1:0]        rest,
    output logic                              out_vld,
    output dcr_pkg::side_t                    out_side,
    output logic [dcr_pkg::NUM_W-1:0]         num_x,
    output logic [dcr_pkg::NUM_W-1:0]         num_y,
    output logic [dcr_pkg::DEN_W-1:0]         dd
);
    import dcr_pkg::*;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    side_t sa_reg, sb_reg, sc_reg, sd_reg;
    side_t sa_next, sc_next;

    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, dvxa_reg, dvya_reg;
    logic [RS_W-1:0]          rsa_reg;
    logic                     eqa_reg, mza_reg;
    logic [K_W-1:0]           e_clamp;

    logic signed [PROD_W-1:0] pxx_reg, pyy_reg, pxv_reg, pyv_reg;
    logic signed [DIFF_W-1:0] dxb_reg, dyb_reg;
    logic [RS2_W-1:0]         rs2_reg;
    logic                     eqb_reg, mzb_reg;

    logic signed [DD_W-1:0]   dd_next, dot_next;
    logic signed [DD_W-1:0]   dot_reg, ddc_reg;
    logic signed [DIFF_W-1:0] dxc_reg, dyc_reg;

    logic [DIFF_W-1:0]        adx, ady;
    logic [NUM_W-1:0]         numx_reg, numy_reg;
    logic [DEN_W-1:0]         ddd_reg;

    assign e_clamp = (K_W'(rest) > REST_ONE) ? REST_ONE : K_W'(rest);

    always_comb
    begin
        sa_next         = '0;
        sa_next.vel1x   = first_vel_x;
        sa_next.vel1y   = first_vel_y;
        sa_next.vel2x   = second_vel_x;
        sa_next.vel2y   = second_vel_y;
        sa_next.m1      = first_mass;
        sa_next.m2      = second_mass;
        sa_next.k       = REST_ONE + e_clamp;
    end

    assign dd_next  = DD_W'(pxx_reg) + DD_W'(pyy_reg);
    assign dot_next = DD_W'(pxv_reg) + DD_W'(pyv_reg);

    always_comb
    begin
        sc_next         = sb_reg;
        sc_next.collide = !eqb_reg && !mzb_reg && (dd_next > 0) && (dot_next > 0)
                          && (dd_next <= $signed(DD_W'(rs2_reg)));
        sc_next.sx      = dxb_reg < 0;
        sc_next.sy      = dyb_reg < 0;
    end

    assign adx = (dxc_reg < 0) ? DIFF_W'(-dxc_reg) : DIFF_W'(dxc_reg);
    assign ady = (dyc_reg < 0) ? DIFF_W'(-dyc_reg) : DIFF_W'(dyc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg   <= sa_next;
            dxa_reg  <= DIFF_W'(second_pos_x) - DIFF_W'(first_pos_x);
            dya_reg  <= DIFF_W'(second_pos_y) - DIFF_W'(first_pos_y);
            dvxa_reg <= DIFF_W'(first_vel_x) - DIFF_W'(second_vel_x);
            dvya_reg <= DIFF_W'(first_vel_y) - DIFF_W'(second_vel_y);
            rsa_reg  <= RS_W'(first_radius) + RS_W'(second_radius);
            eqa_reg  <= (first_vel_x == second_vel_x) && (first_vel_y == second_vel_y);
            mza_reg  <= (first_mass == '0) && (second_mass == '0);

            sb_reg  <= sa_reg;
            pxx_reg <= dxa_reg * dxa_reg;
            pyy_reg <= dya_reg * dya_reg;
            pxv_reg <= dxa_reg * dvxa_reg;
            pyv_reg <= dya_reg * dvya_reg;
            rs2_reg <= RS2_W'(rsa_reg) * RS2_W'(rsa_reg);
            dxb_reg <= dxa_reg;
            dyb_reg <= dya_reg;
            eqb_reg <= eqa_reg;
            mzb_reg <= mza_reg;

            sc_reg  <= sc_next;
            dot_reg <= dot_next;
            ddc_reg <= dd_next;
            dxc_reg <= dxb_reg;
            dyc_reg <= dyb_reg;

            sd_reg   <= sc_reg;
            numx_reg <= NUM_W'(dot_reg[DEN_W-1:0]) * NUM_W'(adx);
            numy_reg <= NUM_W'(dot_reg[DEN_W-1:0]) * NUM_W'(ady);
            ddd_reg  <= ddc_reg[DEN_W-1:0];
        end
    end

    assign out_vld  = vd_reg;
    assign out_side = sd_reg;
    assign num_x    = numx_reg;
    assign num_y    = numy_reg;
    assign dd       = ddd_reg;

endmodule

// ===== design/dcr_scale.sv =====
// Impulse scaling: multiplies the projected velocity by each mass and then
// by one plus restitution, and forms the mass-sum divisor. Two stages.
// Depends on dcr_pkg.
module dcr_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  dcr_pkg::side_t            in_side,
    input  logic [dcr_pkg::Q_W-1:0]   qx,
    input  logic [dcr_pkg::Q_W-1:0]   qy,
    output logic                      out_vld,
    output dcr_pkg::side_t            out_side,
    output logic [dcr_pkg::NUM_W-1:0] num1x,
    output logic [dcr_pkg::NUM_W-1:0] num1y,
    output logic [dcr_pkg::NUM_W-1:0] num2x,
    output logic [dcr_pkg::NUM_W-1:0] num2y,
    output logic [dcr_pkg::DEN_W-1:0] den
);
    import dcr_pkg::*;

    logic             v1_reg, v2_reg;
    side_t            s1_reg, s2_reg;
    logic [PM_W-1:0]  p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [NUM_W-1:0] n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic [DEN_W-1:0] den_reg;
    logic [M_W-1:0]   msum;

    assign msum = M_W'(s1_reg.m1) + M_W'(s1_reg.m2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_side;
            p1x_reg <= PM_W'(qx) * PM_W'(in_side.m2);
            p1y_reg <= PM_W'(qy) * PM_W'(in_side.m2);
            p2x_reg <= PM_W'(qx) * PM_W'(in_side.m1);
            p2y_reg <= PM_W'(qy) * PM_W'(in_side.m1);

            s2_reg  <= s1_reg;
            n1x_reg <= NUM_W'(p1x_reg) * NUM_W'(s1_reg.k);
            n1y_reg <= NUM_W'(p1y_reg) * NUM_W'(s1_reg.k);
            n2x_reg <= NUM_W'(p2x_reg) * NUM_W'(s1_reg.k);
            n2y_reg <= NUM_W'(p2y_reg) * NUM_W'(s1_reg.k);
            den_reg <= DEN_W'(msum) << REST_FRAC;
        end
    end

    assign out_vld  = v2_reg;
    assign out_side = s2_reg;
    assign num1x    = n1x_reg;
    assign num1y    = n1y_reg;
    assign num2x    = n2x_reg;
    assign num2y    = n2y_reg;
    assign den      = den_reg;

endmodule

// ===== design/disk_collision_response_core.sv =====
// Top level of the two-disk collision response pipeline with restitution.
// Depends on dcr_pkg, dcr_front, dcr_div and dcr_scale.
//
// Channel   Handshake                 Payload
// input     in_valid / in_stall       positions, velocities, radii, masses
// output    out_valid / out_stall     new velocities, collided
// config    cfg_valid / cfg_ready     restitution (Q1.15)
//
// One item enters per cycle while in_stall is low; each item passes four
// geometry stages, two 19-stage dividers (projection and impulse), two
// scaling stages and the output register. Reset clears all valid bits and
// loads restitution with about 0.9. While a result waits under out_stall
// the whole pipeline holds and in_stall is raised.
module disk_collision_response_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_pos_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_pos_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_pos_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_pos_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_vel_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] first_vel_y,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_vel_x,
    input  logic signed [dcr_pkg::DATA_W-1:0] second_vel_y,
    input  logic [dcr_pkg::RAD_W-1:0]         first_radius,
    input  logic [dcr_pkg::RAD_W-1:0]         second_radius,
    input  logic [dcr_pkg::MASS_W-1:0]        first_mass,
    input  logic [dcr_pkg::MASS_W-1:0]        second_mass,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dcr_pkg::DATA_W-1:0] new_first_vel_x,
    output logic signed [dcr_pkg::DATA_W-1:0] new_first_vel_y,
    output logic signed [dcr_pkg::DATA_W-1:0] new_second_vel_x,
    output logic signed [dcr_pkg::DATA_W-1:0] new_second_vel_y,
    output logic                              collided,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcr_pkg::REST_W-1:0]        restitution
);
    import dcr_pkg::*;

    logic              en;
    logic [REST_W-1:0] rest_reg;

    logic              front_vld;
    side_t             front_side;
    logic [NUM_W-1:0]  front_numx, front_numy;
    logic [DEN_W-1:0]  front_dd;
    logic [Q_W-1:0]    qx, qy;

    logic              vld1_reg [Q_W];
    side_t             sd1_reg  [Q_W];

    logic              scale_vld;
    side_t             scale_side;
    logic [NUM_W-1:0]  n1x, n1y, n2x, n2y;
    logic [DEN_W-1:0]  scale_den;
    logic [Q_W-1:0]    d1x, d1y, d2x, d2y;

    logic              vld2_reg [Q_W];
    side_t             sd2_reg  [Q_W];
    side_t             fin;

    logic signed [SUM_W-1:0] s1x, s1y, s2x, s2y;

    logic                     out_valid_reg, collided_reg;
    logic signed [DATA_W-1:0] o1x_reg, o1y_reg, o2x_reg, o2y_reg;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= REST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rest_reg <= restitution;
        end
    end

    dcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .first_pos_x   (first_pos_x),
        .first_pos_y   (first_pos_y),
        .second_pos_x  (second_pos_x),
        .second_pos_y  (second_pos_y),
        .first_vel_x   (first_vel_x),
        .first_vel_y   (first_vel_y),
        .second_vel_x  (second_vel_x),
        .second_vel_y  (second_vel_y),
        .first_radius  (first_radius),
        .second_radius (second_radius),
        .first_mass    (first_mass),
        .second_mass   (second_mass),
        .rest          (rest_reg),
        .out_vld       (front_vld),
        .out_side      (front_side),
        .num_x         (front_numx),
        .num_y         (front_numy),
        .dd            (front_dd)
    );

    dcr_div u_div_qx (.clk(clk), .en(en), .mag(front_numx), .den(front_dd), .quo(qx));
    dcr_div u_div_qy (.clk(clk), .en(en), .mag(front_numy), .den(front_dd), .quo(qy));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Q_W; i++)
            begin
                vld1_reg[i] <= 1'b0;
                vld2_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld1_reg[0] <= front_vld;
            vld2_reg[0] <= scale_vld;
            for (int i = 1; i < Q_W; i++)
            begin
                vld1_reg[i] <= vld1_reg[i-1];
                vld2_reg[i] <= vld2_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd1_reg[0] <= front_side;
            sd2_reg[0] <= scale_side;
            for (int i = 1; i < Q_W; i++)
            begin
                sd1_reg[i] <= sd1_reg[i-1];
                sd2_reg[i] <= sd2_reg[i-1];
            end
        end
    end

    dcr_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld1_reg[Q_W-1]),
        .in_side  (sd1_reg[Q_W-1]),
        .qx       (qx),
        .qy       (qy),
        .out_vld  (scale_vld),
        .out_side (scale_side),
        .num1x    (n1x),
        .num1y    (n1y),
        .num2x    (n2x),
        .num2y    (n2y),
        .den      (scale_den)
    );

    dcr_div u_div_d1x (.clk(clk), .en(en), .mag(n1x), .den(scale_den), .quo(d1x));
    dcr_div u_div_d1y (.clk(clk), .en(en), .mag(n1y), .den(scale_den), .quo(d1y));
    dcr_div u_div_d2x (.clk(clk), .en(en), .mag(n2x), .den(scale_den), .quo(d2x));
    dcr_div u_div_d2y (.clk(clk), .en(en), .mag(n2y), .den(scale_den), .quo(d2y));

    assign fin = sd2_reg[Q_W-1];

    assign s1x = fin.sx ? SUM_W'(fin.vel1x) + $signed(SUM_W'(d1x))
                        : SUM_W'(fin.vel1x) - $signed(SUM_W'(d1x));
    assign s1y = fin.sy ? SUM_W'(fin.vel1y) + $signed(SUM_W'(d1y))
                        : SUM_W'(fin.vel1y) - $signed(SUM_W'(d1y));
    assign s2x = fin.sx ? SUM_W'(fin.vel2x) - $signed(SUM_W'(d2x))
                        : SUM_W'(fin.vel2x) + $signed(SUM_W'(d2x));
    assign s2y = fin.sy ? SUM_W'(fin.vel2y) - $signed(SUM_W'(d2y))
                        : SUM_W'(fin.vel2y) + $signed(SUM_W'(d2y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld2_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            collided_reg <= fin.collide;
            o1x_reg      <= fin.collide ? sat_out(s1x) : fin.vel1x;
            o1y_reg      <= fin.collide ? sat_out(s1y) : fin.vel1y;
            o2x_reg      <= fin.collide ? sat_out(s2x) : fin.vel2x;
            o2y_reg      <= fin.collide ? sat_out(s2y) : fin.vel2y;
        end
    end

    assign out_valid        = out_valid_reg;
    assign collided         = collided_reg;
    assign new_first_vel_x  = o1x_reg;
    assign new_first_vel_y  = o1y_reg;
    assign new_second_vel_x = o2x_reg;
    assign new_second_vel_y = o2y_reg;

`ifndef NO_ASSERTIONS
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stall raised without a waiting result.");

    a_dd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        front_vld && front_side.collide |-> front_dd != '0)
        else $error("Colliding item reached the projection divider with zero distance.");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        scale_vld && scale_side.collide |-> scale_den != '0)
        else $error("Colliding item reached the impulse divider with zero mass sum.");
`endif

endmodule
